/* hw/rtl/xxtea_pkg.sv */
// Package for the XXTEA 128-bit block encryption core.
// Holds the cipher constants, the register index codes and the round sum helper.
// Used by xxtea_mix_step and xxtea_block_encrypt_core; depends on nothing else.
package xxtea_pkg;

   localparam int WordW     = 32;
   localparam int NumWords  = 4;
   localparam int NumCycles = 19;
   localparam int NumSteps  = NumCycles * NumWords;

   localparam logic [WordW-1:0] XX_DELTA = 32'h9e37_79b9;

   // Width of the register index on the configuration port.
   localparam int CsrIndexW = 3;

   typedef enum logic [CsrIndexW-1:0] {
      CSR_KEY_WORD_0 = 3'd0,
      CSR_KEY_WORD_1 = 3'd1,
      CSR_KEY_WORD_2 = 3'd2,
      CSR_KEY_WORD_3 = 3'd3
   } csr_index_type;

   typedef logic [WordW-1:0] word_type;
   typedef word_type block_type [NumWords];

   // Round sum of full cycle c (counting from zero): (c+1) times delta, modulo 2^32.
   function automatic word_type round_sum(input int c);
      word_type acc;
      acc = '0;
      for (int i = 0; i <= c; i++) begin
         acc = acc + XX_DELTA;
      end
      return acc;
   endfunction

endpackage

/* hw/rtl/xxtea_mix_step.sv */
// One XXTEA word update: the MX mixing function added to the current word.
// Depends on xxtea_pkg for the word type.
module xxtea_mix_step import xxtea_pkg::*; (
   input  word_type cur_word,
   input  word_type next_word,
   input  word_type prev_word,
   input  word_type sum,
   input  word_type key_word,
   output word_type new_word
);

   word_type shift_mix;
   word_type key_mix;

   // The two halves of MX are independent adds that run side by side.
   assign shift_mix = ((prev_word >> 5) ^ (next_word << 2)) +
                      ((next_word >> 3) ^ (prev_word << 4));
   assign key_mix   = (sum ^ next_word) + (key_word ^ prev_word);

   assign new_word  = cur_word + (shift_mix ^ key_mix);

endmodule

/* hw/rtl/xxtea_block_encrypt_core.sv */
// XXTEA encryption core for one 128-bit block under a 128-bit key (n = 4, 19 full rounds).
// Depends on xxtea_pkg and xxtea_mix_step.
//
// The core takes one plaintext block per clock and returns one ciphertext block per
// clock once full, unless the result side stalls. Each of the 76 word updates (19
// rounds of four words) has its own pipeline stage, so a block passes through one
// input register, 76 update stages and the output register before its result is
// offered. Sustained throughput is one block per cycle without result stalls, set by
// the single update per stage. When the result side stalls, a skid register catches
// the block leaving the pipeline and the whole pipeline then holds until the output
// register drains, so blocks are neither dropped nor repeated. Key words are written
// through the csr_ port (indices 0 to 3; other indices are ignored), always ready,
// and must only be changed while no block is in flight. The key resets to all zeros.
module xxtea_block_encrypt_core import xxtea_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   // Plaintext channel
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [WordW-1:0]     req_plain_word_0,
   input  logic [WordW-1:0]     req_plain_word_1,
   input  logic [WordW-1:0]     req_plain_word_2,
   input  logic [WordW-1:0]     req_plain_word_3,
   // Ciphertext channel
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [WordW-1:0]     rsp_cipher_word_0,
   output logic [WordW-1:0]     rsp_cipher_word_1,
   output logic [WordW-1:0]     rsp_cipher_word_2,
   output logic [WordW-1:0]     rsp_cipher_word_3,
   // Key register write port
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CsrIndexW-1:0] csr_index,
   input  logic [WordW-1:0]     csr_wdata
);

   word_type key_ff [NumWords];

   logic     stage_valid_ff [NumSteps+1];
   block_type stage_word_ff [NumSteps+1];

   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   block_type rsp_word_ff;
   block_type rsp_word_in;
   logic      skid_valid_ff;
   logic      skid_valid_in;
   block_type skid_word_ff;

   logic pipe_en;
   logic rsp_free;
   logic last_valid;

   // Key registers: the write port never pushes back.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NumWords; i++) begin
            key_ff[i] <= '0;
         end
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_KEY_WORD_0: key_ff[0] <= csr_wdata;
            CSR_KEY_WORD_1: key_ff[1] <= csr_wdata;
            CSR_KEY_WORD_2: key_ff[2] <= csr_wdata;
            CSR_KEY_WORD_3: key_ff[3] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // The pipeline moves as one while the skid register is empty.
   assign pipe_en    = !skid_valid_ff;
   assign req_stall  = skid_valid_ff;
   assign last_valid = stage_valid_ff[NumSteps];

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff[0] <= 1'b0;
      end else if (pipe_en) begin
         stage_valid_ff[0] <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en && req_valid) begin
         stage_word_ff[0][0] <= req_plain_word_0;
         stage_word_ff[0][1] <= req_plain_word_1;
         stage_word_ff[0][2] <= req_plain_word_2;
         stage_word_ff[0][3] <= req_plain_word_3;
      end
   end

   // One stage per word update; step k belongs to cycle k/4 and updates word k%4.
   for (genvar k = 0; k < NumSteps; k++) begin : g_step
      localparam int       Cyc  = k / NumWords;
      localparam int       Pos  = k % NumWords;
      localparam word_type Sum  = round_sum(Cyc);
      localparam logic [1:0] KSel = 2'(Pos) ^ Sum[3:2];

      word_type word_in;

      xxtea_mix_step u_mix (
         .cur_word  (stage_word_ff[k][Pos]),
         .next_word (stage_word_ff[k][(Pos + 1) % NumWords]),
         .prev_word (stage_word_ff[k][(Pos + NumWords - 1) % NumWords]),
         .sum       (Sum),
         .key_word  (key_ff[KSel]),
         .new_word  (word_in)
      );

      always_ff @(posedge clock) begin
         if (reset) begin
            stage_valid_ff[k+1] <= 1'b0;
         end else if (pipe_en) begin
            stage_valid_ff[k+1] <= stage_valid_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (pipe_en) begin
            for (int w = 0; w < NumWords; w++) begin
               stage_word_ff[k+1][w] <= (w == Pos) ? word_in : stage_word_ff[k][w];
            end
         end
      end
   end

   // Output register with a skid register behind it.
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_word_in   = rsp_word_ff;
      skid_valid_in = skid_valid_ff;
      if (rsp_free) begin
         if (skid_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_word_in   = skid_word_ff;
            skid_valid_in = 1'b0;
         end else begin
            rsp_valid_in = last_valid;
            rsp_word_in  = stage_word_ff[NumSteps];
         end
      end else if (pipe_en && last_valid) begin
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
      if (!rsp_free && pipe_en && last_valid) begin
         skid_word_ff <= stage_word_ff[NumSteps];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_cipher_word_0 = rsp_word_ff[0];
   assign rsp_cipher_word_1 = rsp_word_ff[1];
   assign rsp_cipher_word_2 = rsp_word_ff[2];
   assign rsp_cipher_word_3 = rsp_word_ff[3];

   // The skid register only fills behind a held output register.
   a_skid_behind_rsp: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid register full while output register empty");

   // A transfer out of the output register drains the skid register into it.
   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && !rsp_stall) |=> (rsp_valid_ff && !skid_valid_ff))
      else $error("skid register not drained after output transfer");

   // While the skid register is full the pipeline end holds its block.
   a_pipe_frozen: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |=> $stable(stage_valid_ff[NumSteps]))
      else $error("pipeline advanced while skid register full");

endmodule

/* tb/tb.sv */
// Self-checking testbench for xxtea_block_encrypt_core, the 128-bit XXTEA block encryption core.
// Holds a scoreboard class with its own cipher predictor, the stimulus tasks and the checks.
// Depends on xxtea_pkg for widths, the delta constant and the key register indexes.
module tb import xxtea_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   // Four words of a block or a key, word 0 in the lowest 32 bits.
   typedef logic [NumWords-1:0][WordW-1:0] block_words;

   localparam int PipeLatency = 78;
   localparam int CycleLimit  = 300000;
   localparam int CsrIndexTop = 2 ** CsrIndexW - 1;
   localparam int PhaseItems  = 150;
   localparam int NumPhases   = 8;

   // Scoreboard: keeps a copy of the key and the ciphertexts still to come.
   class xxtea_scoreboard;
      word_type   key [NumWords];
      block_words pending_cipher [$];
      int unsigned errors;

      function new();
         foreach (key[i]) key[i] = '0;
         errors = 0;
      endfunction

      // Register writes beyond the four key words leave the key unchanged.
      function void load_key(logic [CsrIndexW-1:0] index, word_type value);
         if (index < NumWords) key[index[1:0]] = value;
      endfunction

      // 19 full XXTEA rounds over four words, all sums modulo 2^32.
      function block_words encipher(block_words plain);
         block_words v;
         word_type   rsum;
         word_type   y;
         word_type   z;
         word_type   mixed;
         logic [1:0] ksel;
         v = plain;
         rsum = '0;
         for (int c = 0; c < NumCycles; c++) begin
            rsum = rsum + XX_DELTA;
            for (int p = 0; p < NumWords; p++) begin
               y = v[(p + 1) % NumWords];
               z = v[(p + NumWords - 1) % NumWords];
               ksel = 2'(p) ^ rsum[3:2];
               mixed = (((z >> 5) ^ (y << 2)) + ((y >> 3) ^ (z << 4)))
                     ^ ((rsum ^ y) + (key[ksel] ^ z));
               v[p] = v[p] + mixed;
            end
         end
         return v;
      endfunction

      function void note_plaintext(block_words plain);
         pending_cipher.push_back(encipher(plain));
      endfunction

      function void check_ciphertext(block_words got);
         block_words want;
         if (pending_cipher.size() == 0) begin
            $error("ciphertext transfer with no block outstanding: %h", got);
            errors++;
            return;
         end
         want = pending_cipher.pop_front();
         for (int p = 0; p < NumWords; p++) begin
            if (got[p] !== want[p]) begin
               $error("cipher_word_%0d: expected %08h, actual %08h", p, want[p], got[p]);
               errors++;
            end
         end
      endfunction

      function int outstanding();
         return pending_cipher.size();
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [WordW-1:0]     req_plain_word_0;
   logic [WordW-1:0]     req_plain_word_1;
   logic [WordW-1:0]     req_plain_word_2;
   logic [WordW-1:0]     req_plain_word_3;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [WordW-1:0]     rsp_cipher_word_0;
   logic [WordW-1:0]     rsp_cipher_word_1;
   logic [WordW-1:0]     rsp_cipher_word_2;
   logic [WordW-1:0]     rsp_cipher_word_3;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CsrIndexW-1:0] csr_index;
   logic [WordW-1:0]     csr_wdata;

   xxtea_scoreboard sb;
   int              req_idle_pct;
   int              rsp_stall_pct;
   int              cycle_count;

   xxtea_block_encrypt_core u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_plain_word_0  (req_plain_word_0),
      .req_plain_word_1  (req_plain_word_1),
      .req_plain_word_2  (req_plain_word_2),
      .req_plain_word_3  (req_plain_word_3),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_cipher_word_0 (rsp_cipher_word_0),
      .rsp_cipher_word_1 (rsp_cipher_word_1),
      .rsp_cipher_word_2 (rsp_cipher_word_2),
      .rsp_cipher_word_3 (rsp_cipher_word_3),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Watchdog: the run is cut short if it goes on far beyond its expected length.
   initial begin
      cycle_count = 0;
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb: done, errors");
      $finish;
   end

   // The ciphertext side stalls at random, decided afresh on every falling edge.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         rsp_stall = ($urandom_range(99) < rsp_stall_pct);
      end
   end

   // Every transfer on the three channels is seen here, at the rising edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) sb.load_key(csr_index, csr_wdata);
         if (req_valid && !req_stall)
            sb.note_plaintext({req_plain_word_3, req_plain_word_2,
                               req_plain_word_1, req_plain_word_0});
         if (rsp_valid && !rsp_stall)
            sb.check_ciphertext({rsp_cipher_word_3, rsp_cipher_word_2,
                                 rsp_cipher_word_1, rsp_cipher_word_0});
      end
   end

   // Offers one plaintext block, after random idle cycles, and holds it until taken.
   task automatic send_block(block_words blk);
      while ($urandom_range(99) < req_idle_pct) begin
         @(negedge clock);
         req_valid = 1'b0;
      end
      @(negedge clock);
      req_valid        = 1'b1;
      req_plain_word_0 = blk[0];
      req_plain_word_1 = blk[1];
      req_plain_word_2 = blk[2];
      req_plain_word_3 = blk[3];
      do @(posedge clock); while (req_stall);
   endtask

   // Stops offering blocks and waits until every ciphertext has come back.
   task automatic drain_pipeline();
      @(negedge clock);
      req_valid = 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
   endtask

   task automatic write_csr(logic [CsrIndexW-1:0] index, word_type value);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = index;
      csr_wdata = value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic write_key(block_words k);
      write_csr(CSR_KEY_WORD_0, k[0]);
      write_csr(CSR_KEY_WORD_1, k[1]);
      write_csr(CSR_KEY_WORD_2, k[2]);
      write_csr(CSR_KEY_WORD_3, k[3]);
   endtask

   // Mostly random words, with a share of all-zero, all-one and single-bit words.
   function automatic word_type rand_word();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         2: return word_type'(1) << $urandom_range(WordW - 1);
         default: return $urandom;
      endcase
   endfunction

   function automatic block_words rand_block();
      block_words blk;
      for (int p = 0; p < NumWords; p++) blk[p] = rand_word();
      return blk;
   endfunction

   initial begin
      block_words key_val;
      sb               = new();
      req_idle_pct     = 0;
      rsp_stall_pct    = 0;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_plain_word_0 = '0;
      req_plain_word_1 = '0;
      req_plain_word_2 = '0;
      req_plain_word_3 = '0;
      csr_valid        = 1'b0;
      csr_index        = CSR_KEY_WORD_0;
      csr_wdata        = '0;
      repeat (6) @(negedge clock);
      reset = 1'b0;

      // Directed blocks under the all-zero key left by reset.
      send_block('0);
      send_block('1);
      send_block({NumWords{32'h8000_0000}});
      send_block({NumWords{32'h0000_0001}});
      send_block({32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa});
      send_block({32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'hffff_ffff});
      send_block({32'hffff_ffff, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000});

      // All-ones key, then a write to an unmapped index that must change nothing.
      drain_pipeline();
      write_key('1);
      write_csr(CsrIndexW'($urandom_range(CsrIndexTop, NumWords)), $urandom);
      send_block('0);
      send_block('1);
      send_block({32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555});

      // Key with alternating extremes between its words.
      drain_pipeline();
      write_key({32'hffff_ffff, 32'h0000_0000, 32'hffff_ffff, 32'h0000_0000});
      send_block('0);
      send_block({32'h0000_0001, 32'h8000_0000, 32'h0000_0001, 32'h8000_0000});

      // Random phases, each with its own key and one of four idling patterns.
      for (int phase = 0; phase < NumPhases; phase++) begin
         drain_pipeline();
         if (phase == 1) key_val = '0;
         else if (phase == 5) key_val = '1;
         else key_val = rand_block();
         write_key(key_val);
         if (phase % 3 == 0)
            write_csr(CsrIndexW'($urandom_range(CsrIndexTop, NumWords)), $urandom);
         case (phase % 4)
            0: begin req_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin req_idle_pct = 51; rsp_stall_pct = 0;  end
            2: begin req_idle_pct = 0;  rsp_stall_pct = 51; end
            default: begin req_idle_pct = 6; rsp_stall_pct = 6; end
         endcase
         for (int n = 0; n < PhaseItems; n++) begin
            // Hold off mid-phase once until the pipeline has emptied completely.
            if (phase == 2 && n == PhaseItems / 2) drain_pipeline();
            send_block(rand_block());
         end
      end

      drain_pipeline();
      repeat (PipeLatency + 20) @(posedge clock);
      sb.errors += sb.outstanding();
      if (sb.errors == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule
